/* rtl/ssms_pkg.sv */
package ssms_pkg;

    localparam int unsigned SPEED_W = 8;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] SLEW_RESET    = 8'd15;
    localparam logic [CFG_W-1:0] FLOOR_RESET   = 8'd60;
    localparam logic [CFG_W-1:0] CEILING_RESET = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLEW_RATE     = 2'd0,
        REG_SPEED_FLOOR   = 2'd1,
        REG_SPEED_CEILING = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_COMMAND = 2'd0,
        MODE_SPEED   = 2'd1,
        MODE_TICK    = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CMD_STOP        = 3'd0,
        CMD_FORWARD     = 3'd1,
        CMD_BACKWARD    = 3'd2,
        CMD_TURN_LEFT   = 3'd3,
        CMD_TURN_RIGHT  = 3'd4,
        CMD_SPIN_LEFT   = 3'd5,
        CMD_SPIN_RIGHT  = 3'd6,
        CMD_INVALID     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_BRAKE    = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        RUN_IDLE   = 2'b01,
        RUN_MOVING = 2'b10
    } t_run;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_REJECTED = 1'b1
    } t_status;

    typedef struct packed {
        t_dir               left_dir;
        t_dir               right_dir;
        logic [SPEED_W-1:0] left_pwm;
        logic [SPEED_W-1:0] right_pwm;
        logic               moving;
        t_status            status;
    } t_result;

    function automatic logic [SPEED_W-1:0] limit_speed(
        input logic [SPEED_W-1:0] s,
        input logic [SPEED_W-1:0] floor_v,
        input logic [SPEED_W-1:0] ceiling_v
    );
        logic [SPEED_W-1:0] r;
        if (s < floor_v) begin
            r = floor_v;
        end else if (s > ceiling_v) begin
            r = ceiling_v;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

/* rtl/ssms_in_if.sv */
interface ssms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] command;
    logic [7:0] speed;

    modport source (output valid, output mode, output command, output speed, input ready);
    modport sink   (input valid, input mode, input command, input speed, output ready);
endinterface

/* rtl/ssms_out_if.sv */
interface ssms_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] left_direction;
    logic [1:0] right_direction;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic       moving;
    logic       status;

    modport source (
        output valid, output left_direction, output right_direction,
        output left_pwm, output right_pwm, output moving, output status,
        input ready
    );
    modport sink (
        input valid, input left_direction, input right_direction,
        input left_pwm, input right_pwm, input moving, input status,
        output ready
    );
endinterface

/* rtl/ssms_core.sv */
module ssms_core
    import ssms_pkg::*;
#(
    parameter int unsigned START_SPEED = 60
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [1:0]           i_mode,
    input  logic [2:0]           i_command,
    input  logic [SPEED_W-1:0]   i_speed,
    output t_result              o_result
);

    localparam logic [SPEED_W-1:0] INIT_TARGET =
        limit_speed(SPEED_W'(START_SPEED), FLOOR_RESET, CEILING_RESET);

    logic [CFG_W-1:0]   r_slew;
    logic [CFG_W-1:0]   r_floor;
    logic [CFG_W-1:0]   r_ceiling;

    logic [SPEED_W-1:0] r_target, n_target;
    logic [SPEED_W-1:0] r_goal, n_goal;
    logic [SPEED_W-1:0] r_level, n_level;
    t_cmd               r_active, n_active;
    t_run               r_run, n_run;
    t_dir               r_left_dir, n_left_dir;
    t_dir               r_right_dir, n_right_dir;
    logic [SPEED_W-1:0] r_left_pwm, n_left_pwm;
    logic [SPEED_W-1:0] r_right_pwm, n_right_pwm;

    t_status            status;
    logic               drive;
    logic [SPEED_W-1:0] diff_up;
    logic [SPEED_W-1:0] diff_dn;
    logic [SPEED_W-1:0] ramp_next;
    t_cmd               cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew    <= SLEW_RESET;
            r_floor   <= FLOOR_RESET;
            r_ceiling <= CEILING_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_SLEW_RATE:     r_slew    <= i_cfg_data;
                REG_SPEED_FLOOR:   r_floor   <= i_cfg_data;
                REG_SPEED_CEILING: r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // slew-limited step of the ramp toward its goal
    always_comb begin
        diff_up = r_goal - r_level;
        diff_dn = r_level - r_goal;
        if (r_level < r_goal) begin
            ramp_next = r_level + ((diff_up < r_slew) ? diff_up : r_slew);
        end else if (r_level > r_goal) begin
            ramp_next = r_level - ((diff_dn < r_slew) ? diff_dn : r_slew);
        end else begin
            ramp_next = r_level;
        end
    end

    always_comb begin
        cmd         = t_cmd'(i_command);
        n_target    = r_target;
        n_goal      = r_goal;
        n_level     = r_level;
        n_active    = r_active;
        n_run       = r_run;
        n_left_dir  = r_left_dir;
        n_right_dir = r_right_dir;
        n_left_pwm  = r_left_pwm;
        n_right_pwm = r_right_pwm;
        status      = STATUS_OK;
        drive       = 1'b0;

        case (t_mode'(i_mode))
            MODE_COMMAND: begin
                case (cmd)
                    CMD_STOP: begin
                        n_left_dir  = DIR_BRAKE;
                        n_right_dir = DIR_BRAKE;
                        n_left_pwm  = '0;
                        n_right_pwm = '0;
                        n_goal      = '0;
                        n_level     = '0;
                        n_active    = CMD_STOP;
                        n_run       = RUN_IDLE;
                    end
                    CMD_INVALID: begin
                        n_active = cmd;
                        status   = STATUS_REJECTED;
                    end
                    default: begin
                        n_active = cmd;
                        n_goal   = r_target;
                        n_run    = RUN_MOVING;
                        drive    = 1'b1;
                        case (cmd)
                            CMD_FORWARD: begin
                                n_left_dir  = DIR_FORWARD;
                                n_right_dir = DIR_FORWARD;
                            end
                            CMD_BACKWARD: begin
                                n_left_dir  = DIR_BACKWARD;
                                n_right_dir = DIR_BACKWARD;
                            end
                            CMD_TURN_LEFT: begin
                                n_left_dir  = DIR_BRAKE;
                                n_right_dir = DIR_FORWARD;
                            end
                            CMD_TURN_RIGHT: begin
                                n_left_dir  = DIR_FORWARD;
                                n_right_dir = DIR_BRAKE;
                            end
                            CMD_SPIN_LEFT: begin
                                n_left_dir  = DIR_BACKWARD;
                                n_right_dir = DIR_FORWARD;
                            end
                            default: begin
                                n_left_dir  = DIR_FORWARD;
                                n_right_dir = DIR_BACKWARD;
                            end
                        endcase
                    end
                endcase
            end
            MODE_SPEED: begin
                n_target = limit_speed(i_speed, r_floor, r_ceiling);
                if (r_run == RUN_MOVING && r_active != CMD_STOP) begin
                    n_goal = n_target;
                end
            end
            MODE_TICK: begin
                if (r_run == RUN_MOVING) begin
                    n_level = ramp_next;
                    drive   = 1'b1;
                end
            end
            default: ;
        endcase

        // track duty from the command in force and the ramped level
        if (drive) begin
            case (n_active)
                CMD_FORWARD, CMD_BACKWARD, CMD_SPIN_LEFT, CMD_SPIN_RIGHT: begin
                    n_left_pwm  = n_level;
                    n_right_pwm = n_level;
                end
                CMD_TURN_LEFT: begin
                    n_left_pwm  = '0;
                    n_right_pwm = n_level;
                end
                CMD_TURN_RIGHT: begin
                    n_left_pwm  = n_level;
                    n_right_pwm = '0;
                end
                default: begin
                    n_left_pwm  = '0;
                    n_right_pwm = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= INIT_TARGET;
            r_goal      <= '0;
            r_level     <= '0;
            r_active    <= CMD_STOP;
            r_run       <= RUN_IDLE;
            r_left_dir  <= DIR_BRAKE;
            r_right_dir <= DIR_BRAKE;
            r_left_pwm  <= '0;
            r_right_pwm <= '0;
        end else if (i_accept) begin
            r_target    <= n_target;
            r_goal      <= n_goal;
            r_level     <= n_level;
            r_active    <= n_active;
            r_run       <= n_run;
            r_left_dir  <= n_left_dir;
            r_right_dir <= n_right_dir;
            r_left_pwm  <= n_left_pwm;
            r_right_pwm <= n_right_pwm;
        end
    end

    always_comb begin
        o_result.left_dir  = n_left_dir;
        o_result.right_dir = n_right_dir;
        o_result.left_pwm  = n_left_pwm;
        o_result.right_pwm = n_right_pwm;
        o_result.moving    = (n_run == RUN_MOVING);
        o_result.status    = status;
    end

endmodule

/* rtl/ssms_outbuf.sv */
module ssms_outbuf
    import ssms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_result;
        end
    end

endmodule

/* rtl/skid_steer_motion_sequencer_top.sv */
// channel   dir  transfer             payload
// i_in      in   valid & ready        mode, command, speed
// o_out     out  valid & ready        left/right direction, left/right pwm, moving, status
// i_cfg_*   in   i_cfg_we             i_cfg_idx selects slew, floor, ceiling; i_cfg_data
//
// one item per cycle while i_in.ready is high; its result is registered in the output stage
// state updates in one pass of compare, subtract and add logic in ssms_core
// a two-entry output stage keeps i_in.ready high while one result waits unclaimed
// i_in.ready drops only when both output entries are full
// reset is synchronous and active low; it restores the registers and brakes both tracks
module skid_steer_motion_sequencer_top
    import ssms_pkg::*;
#(
    parameter int unsigned START_SPEED = 60
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ssms_in_if.sink              i_in,
    ssms_out_if.source           o_out
);

    logic    accept;
    logic    buf_ready;
    t_result core_result;
    t_result out_result;

    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;

    ssms_core #(
        .START_SPEED (START_SPEED)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_mode     (i_in.mode),
        .i_command  (i_in.command),
        .i_speed    (i_in.speed),
        .o_result   (core_result)
    );

    ssms_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_result (core_result),
        .o_ready  (buf_ready),
        .o_valid  (o_out.valid),
        .o_result (out_result),
        .i_ready  (o_out.ready)
    );

    assign o_out.left_direction  = out_result.left_dir;
    assign o_out.right_direction = out_result.right_dir;
    assign o_out.left_pwm        = out_result.left_pwm;
    assign o_out.right_pwm       = out_result.right_pwm;
    assign o_out.moving          = out_result.moving;
    assign o_out.status          = out_result.status;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("no result after input transfer");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty output");

    a_idle_is_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.moving) |->
            (o_out.left_pwm == '0 && o_out.right_pwm == '0
             && o_out.left_direction == DIR_BRAKE && o_out.right_direction == DIR_BRAKE))
        else $error("idle result drives a track");
`endif

endmodule

/* tb/sv/tb_skid_steer_motion_sequencer_top.sv */
`timescale 1ns / 100ps

module tb_skid_steer_motion_sequencer_top;
    import ssms_pkg::*;

    localparam int unsigned START_SPEED   = 60;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PHASE_ITEMS   = 210;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;

    class track_drive_tracker;
        logic [7:0]  slew_rate;
        logic [7:0]  speed_floor;
        logic [7:0]  speed_ceiling;
        logic [7:0]  target_level;
        logic [7:0]  ramp_goal;
        logic [7:0]  ramp_level;
        t_cmd        active_cmd;
        logic        moving;
        t_dir        left_dir;
        t_dir        right_dir;
        logic [7:0]  left_pwm;
        logic [7:0]  right_pwm;
        t_result     expected_drive[$];
        int unsigned mismatch_count;
        int unsigned checked_count;

        function new(int unsigned start_speed);
            slew_rate      = SLEW_RESET;
            speed_floor    = FLOOR_RESET;
            speed_ceiling  = CEILING_RESET;
            mismatch_count = 0;
            checked_count  = 0;
            target_level   = bound_speed(start_speed[7:0]);
            halt();
        endfunction

        function void write_reg(t_cfg_reg idx, logic [7:0] value);
            case (idx)
                REG_SLEW_RATE:     slew_rate = value;
                REG_SPEED_FLOOR:   speed_floor = value;
                REG_SPEED_CEILING: speed_ceiling = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] bound_speed(logic [7:0] s);
            if (s < speed_floor) begin
                return speed_floor;
            end else if (s > speed_ceiling) begin
                return speed_ceiling;
            end
            return s;
        endfunction

        function void halt();
            left_dir   = DIR_BRAKE;
            right_dir  = DIR_BRAKE;
            left_pwm   = '0;
            right_pwm  = '0;
            ramp_goal  = '0;
            ramp_level = '0;
            active_cmd = CMD_STOP;
            moving     = 1'b0;
        endfunction

        function void refresh_pwm();
            left_pwm  = '0;
            right_pwm = '0;
            case (active_cmd)
                CMD_FORWARD, CMD_BACKWARD, CMD_SPIN_LEFT, CMD_SPIN_RIGHT: begin
                    left_pwm  = ramp_level;
                    right_pwm = ramp_level;
                end
                CMD_TURN_LEFT:  right_pwm = ramp_level;
                CMD_TURN_RIGHT: left_pwm = ramp_level;
                default: ;
            endcase
        endfunction

        function void step_ramp();
            logic [7:0] gap;
            if (ramp_level < ramp_goal) begin
                gap = ramp_goal - ramp_level;
                ramp_level = ramp_level + ((gap < slew_rate) ? gap : slew_rate);
            end else if (ramp_level > ramp_goal) begin
                gap = ramp_level - ramp_goal;
                ramp_level = ramp_level - ((gap < slew_rate) ? gap : slew_rate);
            end
        endfunction

        function void apply_item(logic [1:0] mode, logic [2:0] cmd, logic [7:0] spd);
            t_status st;
            t_result r;
            st = STATUS_OK;
            case (mode)
                MODE_COMMAND: begin
                    case (t_cmd'(cmd))
                        CMD_STOP: halt();
                        CMD_INVALID: begin
                            active_cmd = CMD_INVALID;
                            st = STATUS_REJECTED;
                        end
                        default: begin
                            active_cmd = t_cmd'(cmd);
                            case (active_cmd)
                                CMD_FORWARD: begin
                                    left_dir  = DIR_FORWARD;
                                    right_dir = DIR_FORWARD;
                                end
                                CMD_BACKWARD: begin
                                    left_dir  = DIR_BACKWARD;
                                    right_dir = DIR_BACKWARD;
                                end
                                CMD_TURN_LEFT: begin
                                    left_dir  = DIR_BRAKE;
                                    right_dir = DIR_FORWARD;
                                end
                                CMD_TURN_RIGHT: begin
                                    left_dir  = DIR_FORWARD;
                                    right_dir = DIR_BRAKE;
                                end
                                CMD_SPIN_LEFT: begin
                                    left_dir  = DIR_BACKWARD;
                                    right_dir = DIR_FORWARD;
                                end
                                CMD_SPIN_RIGHT: begin
                                    left_dir  = DIR_FORWARD;
                                    right_dir = DIR_BACKWARD;
                                end
                                default: ;
                            endcase
                            ramp_goal = target_level;
                            moving    = 1'b1;
                            refresh_pwm();
                        end
                    endcase
                end
                MODE_SPEED: begin
                    target_level = bound_speed(spd);
                    if (moving && active_cmd != CMD_STOP) begin
                        ramp_goal = target_level;
                    end
                end
                MODE_TICK: begin
                    if (moving) begin
                        step_ramp();
                        refresh_pwm();
                    end
                end
                default: ;
            endcase
            r.left_dir  = left_dir;
            r.right_dir = right_dir;
            r.left_pwm  = left_pwm;
            r.right_pwm = right_pwm;
            r.moving    = moving;
            r.status    = st;
            expected_drive.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatch_count++;
            if (mismatch_count <= 40) begin
                $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            end
        endtask

        task check_drive(t_result got);
            t_result want;
            if (expected_drive.size() == 0) begin
                report_mismatch("result with nothing outstanding", 0, 0);
                return;
            end
            want = expected_drive.pop_front();
            checked_count++;
            if (got.left_dir !== want.left_dir) begin
                report_mismatch("left direction", got.left_dir, want.left_dir);
            end
            if (got.right_dir !== want.right_dir) begin
                report_mismatch("right direction", got.right_dir, want.right_dir);
            end
            if (got.left_pwm !== want.left_pwm) begin
                report_mismatch("left pwm", got.left_pwm, want.left_pwm);
            end
            if (got.right_pwm !== want.right_pwm) begin
                report_mismatch("right pwm", got.right_pwm, want.right_pwm);
            end
            if (got.moving !== want.moving) begin
                report_mismatch("moving", got.moving, want.moving);
            end
            if (got.status !== want.status) begin
                report_mismatch("status", got.status, want.status);
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned items_sent      = 0;

    track_drive_tracker tracker;

    ssms_in_if  in_ch ();
    ssms_out_if out_ch ();

    skid_steer_motion_sequencer_top #(
        .START_SPEED(START_SPEED)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side: check each transfer, then pick the next ready
    initial begin
        t_result got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.left_dir  = t_dir'(out_ch.left_direction);
                got.right_dir = t_dir'(out_ch.right_direction);
                got.left_pwm  = out_ch.left_pwm;
                got.right_pwm = out_ch.right_pwm;
                got.moving    = out_ch.moving;
                got.status    = t_status'(out_ch.status);
                tracker.check_drive(got);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic [2:0] cmd,
                             input logic [7:0] spd);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.command <= cmd;
        in_ch.speed   <= spd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.apply_item(mode, cmd, spd);
        items_sent++;
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [1:0]  mode;
        logic [2:0]  cmd;
        logic [7:0]  spd;
        pick = $urandom_range(0, 99);
        cmd  = 3'($urandom_range(0, 7));
        spd  = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
            spd = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        if (pick < 45) begin
            mode = MODE_TICK;
        end else if (pick < 65) begin
            mode = MODE_SPEED;
        end else if (pick < 88) begin
            mode = MODE_COMMAND;
            cmd  = 3'($urandom_range(CMD_FORWARD, CMD_SPIN_RIGHT));
        end else if (pick < 93) begin
            mode = MODE_COMMAND;
            cmd  = CMD_STOP;
        end else if (pick < 97) begin
            mode = MODE_COMMAND;
            cmd  = CMD_INVALID;
        end else begin
            mode = MODE_UNUSED;
        end
        push_item(mode, cmd, spd);
    endtask

    task automatic program_regs(input logic [7:0] slew, input logic [7:0] floor_v,
                                input logic [7:0] ceiling_v);
        t_cfg_reg   order[3];
        logic [7:0] vals[3];
        order[0] = REG_SLEW_RATE;
        order[1] = REG_SPEED_FLOOR;
        order[2] = REG_SPEED_CEILING;
        vals[0]  = slew;
        vals[1]  = floor_v;
        vals[2]  = ceiling_v;
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= order[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            tracker.write_reg(order[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.expected_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        tracker = new(START_SPEED);
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_SLEW_RATE;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_TICK;
        in_ch.command <= CMD_STOP;
        in_ch.speed   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on reset settings
        push_item(MODE_TICK, CMD_STOP, 8'd0);
        push_item(MODE_COMMAND, CMD_FORWARD, 8'd0);
        repeat (5) push_item(MODE_TICK, CMD_STOP, 8'd0);
        push_item(MODE_SPEED, CMD_STOP, 8'd255);
        push_item(MODE_TICK, CMD_STOP, 8'd0);
        push_item(MODE_SPEED, CMD_STOP, 8'd0);
        push_item(MODE_COMMAND, CMD_TURN_LEFT, 8'd0);
        push_item(MODE_TICK, CMD_STOP, 8'd0);
        push_item(MODE_COMMAND, CMD_TURN_RIGHT, 8'd0);
        push_item(MODE_COMMAND, CMD_SPIN_LEFT, 8'd0);
        push_item(MODE_COMMAND, CMD_SPIN_RIGHT, 8'd0);
        push_item(MODE_COMMAND, CMD_BACKWARD, 8'd0);
        push_item(MODE_COMMAND, CMD_INVALID, 8'd0);
        push_item(MODE_TICK, CMD_STOP, 8'd0);
        push_item(MODE_UNUSED, CMD_INVALID, 8'd255);
        push_item(MODE_COMMAND, CMD_STOP, 8'd0);
        push_item(MODE_SPEED, CMD_STOP, 8'd100);
        push_item(MODE_TICK, CMD_STOP, 8'd0);
        push_item(MODE_COMMAND, CMD_INVALID, 8'd0);
        push_item(MODE_SPEED, CMD_STOP, 8'd30);
        push_item(MODE_COMMAND, CMD_FORWARD, 8'd0);
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: program_regs(SLEW_RESET, FLOOR_RESET, CEILING_RESET);
                1: program_regs(8'd1, 8'd0, 8'd255);
                2: program_regs(8'd255, 8'd0, 8'd255);
                3: program_regs(8'd0, 8'd30, 8'd200);
                4: program_regs(8'd40, 8'd200, 8'd100);
                5: program_regs(8'd7, 8'd255, 8'd255);
                6: program_regs(8'd255, 8'd0, 8'd0);
                default: program_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 120)),
                                      8'($urandom_range(121, 255)));
            endcase
            sender_idle_pct = (p % 4 == 1) ? 64 : (p % 4 == 3) ? 13 : 0;
            sink_stall_pct  = (p % 4 == 2) ? 64 : (p % 4 == 3) ? 13 : 0;
            repeat (PHASE_ITEMS) random_item();
            settle();
        end

        if (tracker.expected_drive.size() != 0) begin
            tracker.report_mismatch("results never delivered", tracker.expected_drive.size(), 0);
        end
        $display("%0d items sent across %0d register settings and four flow patterns",
                 items_sent, PHASE_COUNT + 1);
        $display("%0d results checked, %0d mismatches", tracker.checked_count,
                 tracker.mismatch_count);
        if (tracker.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
